// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL of the keyboard event serializer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, disabled while reset is asserted.
`define ASSERT_CLKD(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/kens_pkg.sv =====
// Package with the types, widths and constants of the keyboard event serializer.
package kens_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int MODE_W   = 3;
    localparam int CODE_W   = 8;
    localparam int PAD_W    = 16;
    localparam int NIBBLE_W = 4;
    localparam int POS_W    = 4;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [7:0]          DEVICE_ID_RESET = 8'h34;
    localparam logic [7:0]          GAME_LOW_MASK   = 8'hF8;
    localparam logic [NIBBLE_W-1:0] STATUS_EMPTY    = 4'h6;
    localparam logic [NIBBLE_W-1:0] STATUS_BREAK    = 4'h7;
    localparam logic [NIBBLE_W-1:0] STATUS_MAKE     = 4'hE;
    localparam logic [POS_W-1:0]    LAST_NIBBLE     = 4'd11;

    typedef enum logic [MODE_W-1:0] {
        MODE_POLL    = 3'd0,
        MODE_MAKE    = 3'd1,
        MODE_BREAK   = 3'd2,
        MODE_RELEASE = 3'd3,
        MODE_RESTART = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        REG_DEVICE_ID   = 2'd0,
        REG_CAPS_LOCK   = 2'd1,
        REG_NUM_LOCK    = 2'd2,
        REG_SCROLL_LOCK = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic              brk;
        logic [CODE_W-1:0] code;
    } event_t;

endpackage

// ===== src/kens_stream_if.sv =====
// Valid/ready stream interfaces for the input and result beats of the serializer.
interface kens_in_if;
    logic                          valid;
    logic                          ready;
    logic [kens_pkg::MODE_W-1:0]   mode;
    logic [kens_pkg::CODE_W-1:0]   key_code;
    logic [kens_pkg::PAD_W-1:0]    pad_buttons;
    logic                          select_low;
    logic                          select_high;

    modport source (output valid, mode, key_code, pad_buttons, select_low, select_high,
                    input ready);
    modport sink (input valid, mode, key_code, pad_buttons, select_low, select_high,
                  output ready);
endinterface

interface kens_out_if;
    logic                            valid;
    logic                            ready;
    logic [kens_pkg::NIBBLE_W-1:0]   data_nibble;
    logic                            push_accepted;

    modport source (output valid, data_nibble, push_accepted, input ready);
    modport sink (input valid, data_nibble, push_accepted, output ready);
endinterface

// ===== src/keyboard_event_nibble_serializer.sv =====
// Keyboard event queue served to a host as 12-nibble packets stepped by two select lines.
// The block takes one input beat per clock cycle unless the result side stalls, and gives one
// result beat for each: an input register captures the beat; the queue, packet multiplexer and
// pointer updates lie combinationally between it and the result register. The event queue is a
// 16-entry flip-flop array read at the read pointer, holding at most 15 events. The user writes
// configuration registers over the APB port only while the block is idle; nothing enforces it.
module keyboard_event_nibble_serializer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kens_pkg::ADDR_W-1:0]   paddr,
    input  logic [kens_pkg::DATA_W-1:0]   pwdata,
    output logic [kens_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    kens_in_if.sink                       in_ch,
    kens_out_if.source                    out_ch
);

    `include "assert_macros.svh"

    // Configuration registers.
    logic [7:0] device_id_reg;
    logic       caps_lock_reg;
    logic       num_lock_reg;
    logic       scroll_lock_reg;
    logic       cfg_write;

    // Input register.
    logic                          in_valid_reg;
    logic [kens_pkg::MODE_W-1:0]   mode_reg;
    logic [kens_pkg::CODE_W-1:0]   key_code_reg;
    logic [kens_pkg::PAD_W-1:0]    pad_reg;
    logic [1:0]                    sel_reg;

    // Result register.
    logic                            out_valid_reg;
    logic [kens_pkg::NIBBLE_W-1:0]   nibble_reg;
    logic                            accepted_reg;

    // Queue and packet state.
    kens_pkg::event_t              store [kens_pkg::QUEUE_DEPTH];
    logic [kens_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [kens_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [kens_pkg::CODE_W-1:0]   last_code_reg, last_code_next;
    logic [kens_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic                          any_sent_reg, any_sent_next;
    logic [1:0]                    prior_sel_reg, prior_sel_next;
    logic                          sel_seen_reg, sel_seen_next;

    logic                            fire;
    logic                            q_empty;
    logic                            q_full;
    kens_pkg::event_t                head;
    logic                            push_req;
    logic                            push_en;
    kens_pkg::event_t                push_entry;
    logic [kens_pkg::NIBBLE_W-1:0]   nibble_next;
    logic                            accepted_next;

    function automatic logic [kens_pkg::QPTR_W-1:0] ptr_inc(
        input logic [kens_pkg::QPTR_W-1:0] ptr
    );
        if (ptr == kens_pkg::QPTR_W'(kens_pkg::QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return ptr + 1'b1;
    endfunction

    function automatic logic [kens_pkg::NIBBLE_W-1:0] nibble_at(
        input logic [kens_pkg::POS_W-1:0] pos,
        input logic [kens_pkg::PAD_W-1:0] pad,
        input kens_pkg::event_t           hd,
        input logic                       empty,
        input logic [7:0]                 dev_id,
        input logic [2:0]                 locks
    );
        logic [7:0] low_byte;
        logic [3:0] status;
        logic [7:0] code;
        low_byte = pad[7:0] & kens_pkg::GAME_LOW_MASK;
        code     = empty ? 8'h00 : hd.code;
        if (empty)
        begin
            status = kens_pkg::STATUS_EMPTY;
        end
        else if (hd.brk)
        begin
            status = kens_pkg::STATUS_BREAK;
        end
        else
        begin
            status = kens_pkg::STATUS_MAKE;
        end
        case (pos)
            4'd0:    return dev_id[7:4];
            4'd1:    return dev_id[3:0];
            4'd2:    return pad[15:12];
            4'd3:    return pad[11:8];
            4'd4:    return low_byte[7:4];
            4'd5:    return low_byte[3:0];
            4'd6:    return {1'b0, locks};
            4'd7:    return status;
            4'd8:    return code[7:4];
            4'd9:    return code[3:0];
            4'd10:   return 4'h0;
            default: return 4'h1;
        endcase
    endfunction

    // APB configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_id_reg   <= kens_pkg::DEVICE_ID_RESET;
            caps_lock_reg   <= 1'b0;
            num_lock_reg    <= 1'b0;
            scroll_lock_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (kens_pkg::reg_index_t'(paddr[3:2]))
                kens_pkg::REG_DEVICE_ID:   device_id_reg   <= pwdata[7:0];
                kens_pkg::REG_CAPS_LOCK:   caps_lock_reg   <= pwdata[0];
                kens_pkg::REG_NUM_LOCK:    num_lock_reg    <= pwdata[0];
                kens_pkg::REG_SCROLL_LOCK: scroll_lock_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (kens_pkg::reg_index_t'(paddr[3:2]))
            kens_pkg::REG_DEVICE_ID:   prdata = {24'h0, device_id_reg};
            kens_pkg::REG_CAPS_LOCK:   prdata = {31'h0, caps_lock_reg};
            kens_pkg::REG_NUM_LOCK:    prdata = {31'h0, num_lock_reg};
            kens_pkg::REG_SCROLL_LOCK: prdata = {31'h0, scroll_lock_reg};
            default:                   prdata = '0;
        endcase
    end

    // The buffered beat moves on when the result register is free or being drained.
    assign fire         = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !in_valid_reg || fire;

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.data_nibble   = nibble_reg;
    assign out_ch.push_accepted = accepted_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                in_valid_reg <= in_ch.valid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            mode_reg     <= in_ch.mode;
            key_code_reg <= in_ch.key_code;
            pad_reg      <= in_ch.pad_buttons;
            sel_reg      <= {in_ch.select_high, in_ch.select_low};
        end
        if (fire)
        begin
            nibble_reg   <= nibble_next;
            accepted_reg <= accepted_next;
        end
    end

    assign q_empty = rd_ptr_reg == wr_ptr_reg;
    assign q_full  = ptr_inc(wr_ptr_reg) == rd_ptr_reg;
    assign head    = store[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        last_code_next = last_code_reg;
        pos_next       = pos_reg;
        any_sent_next  = any_sent_reg;
        prior_sel_next = prior_sel_reg;
        sel_seen_next  = sel_seen_reg;
        nibble_next    = '0;
        push_req       = 1'b0;
        push_entry     = '{brk: 1'b0, code: key_code_reg};

        case (mode_reg)
            kens_pkg::MODE_POLL:
            begin
                if (!sel_seen_reg || sel_reg != prior_sel_reg)
                begin
                    nibble_next = nibble_at(pos_reg, pad_reg, head, q_empty, device_id_reg,
                                            {caps_lock_reg, num_lock_reg, scroll_lock_reg});
                    // Sending the last nibble of a packet retires the head event.
                    if (pos_reg == kens_pkg::LAST_NIBBLE)
                    begin
                        pos_next = '0;
                        if (!q_empty)
                        begin
                            rd_ptr_next = ptr_inc(rd_ptr_reg);
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                    any_sent_next  = 1'b1;
                    prior_sel_next = sel_reg;
                    sel_seen_next  = 1'b1;
                end
                else if (any_sent_reg)
                begin
                    nibble_next = nibble_at(
                        (pos_reg == '0) ? kens_pkg::LAST_NIBBLE : pos_reg - 1'b1,
                        pad_reg, head, q_empty, device_id_reg,
                        {caps_lock_reg, num_lock_reg, scroll_lock_reg});
                end
                else
                begin
                    nibble_next = nibble_at('0, pad_reg, head, q_empty, device_id_reg,
                                            {caps_lock_reg, num_lock_reg, scroll_lock_reg});
                end
            end
            kens_pkg::MODE_MAKE:
            begin
                last_code_next = key_code_reg;
                push_req       = 1'b1;
            end
            kens_pkg::MODE_BREAK:
            begin
                last_code_next = key_code_reg;
                push_req       = 1'b1;
                push_entry     = '{brk: 1'b1, code: key_code_reg};
            end
            kens_pkg::MODE_RELEASE:
            begin
                push_req   = last_code_reg != '0;
                push_entry = '{brk: 1'b1, code: last_code_reg};
            end
            kens_pkg::MODE_RESTART:
            begin
                pos_next      = '0;
                any_sent_next = 1'b0;
                sel_seen_next = 1'b0;
            end
            default: ;
        endcase

        push_en       = push_req && !q_full;
        accepted_next = push_en;
        if (push_en)
        begin
            wr_ptr_next = ptr_inc(wr_ptr_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && push_en)
        begin
            store[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            last_code_reg <= '0;
            pos_reg       <= '0;
            any_sent_reg  <= 1'b0;
            prior_sel_reg <= '0;
            sel_seen_reg  <= 1'b0;
        end
        else if (fire)
        begin
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            last_code_reg <= last_code_next;
            pos_reg       <= pos_next;
            any_sent_reg  <= any_sent_next;
            prior_sel_reg <= prior_sel_next;
            sel_seen_reg  <= sel_seen_next;
        end
    end

    `ASSERT_CLKD(a_pos_in_packet, pos_reg <= kens_pkg::LAST_NIBBLE,
        "nibble position left the packet range")
    `ASSERT_CLKD(a_sent_tracks_seen, any_sent_reg == sel_seen_reg,
        "sent flag and select history disagree")
    `ASSERT_CLKD(a_push_fills_queue, fire && push_en |=> rd_ptr_reg != wr_ptr_reg,
        "queue empty right after an accepted push")
    `ASSERT_CLKD(a_result_kind, out_valid_reg && accepted_reg |-> nibble_reg == '0,
        "push result carries a nonzero nibble")

endmodule

// ===== dv/keyboard_event_nibble_serializer_tb.sv =====
// Self-checking testbench for the keyboard event nibble serializer.
`timescale 1ns / 100ps

module keyboard_event_nibble_serializer_tb;

    import kens_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int PACKET_NIBBLES = 12;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_BEATS    = 250;
    localparam int TAIL_CYCLES    = 16;
    localparam int CYCLE_LIMIT    = 500000;

    // Mode codes outside the decoded set; the block ignores them.
    localparam logic [MODE_W-1:0] MODE_SPARE_LO  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_MID = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI  = 3'd7;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CODE_W-1:0] key;
        logic [PAD_W-1:0]  pad;
        logic              sel_hi;
        logic              sel_lo;
    } kens_beat_t;

    typedef struct packed {
        logic [NIBBLE_W-1:0] nibble;
        logic                accepted;
    } kens_result_t;

    typedef struct packed {
        kens_beat_t   beat;
        logic         typed;
        kens_result_t want;
    } directed_row_t;

    // Empty-queue packet with all pad bits set, select stepping through all four
    // codes, then the push, release, ignored-mode and restart corner cases.
    localparam directed_row_t DIRECTED_ROWS [25] = '{
        '{'{MODE_POLL,      8'h00, 16'hFFFF, 1'b0, 1'b0}, 1'b1, '{4'h3, 1'b0}},
        '{'{MODE_POLL,      8'h00, 16'hFFFF, 1'b0, 1'b1}, 1'b1, '{4'h4, 1'b0}},
        '{'{MODE_POLL,      8'hFF, 16'hFFFF, 1'b1, 1'b1}, 1'b1, '{4'hF, 1'b0}},
        '{'{MODE_POLL,      8'h00, 16'hFFFF, 1'b1, 1'b0}, 1'b1, '{4'hF, 1'b0}},
        '{'{MODE_POLL,      8'h00, 16'hFFFF, 1'b0, 1'b0}, 1'b1, '{4'hF, 1'b0}},
        '{'{MODE_POLL,      8'h00, 16'hFFFF, 1'b0, 1'b1}, 1'b1, '{4'h8, 1'b0}},
        '{'{MODE_POLL,      8'h00, 16'hFFFF, 1'b1, 1'b1}, 1'b1, '{4'h0, 1'b0}},
        '{'{MODE_POLL,      8'h00, 16'hFFFF, 1'b1, 1'b0}, 1'b1, '{4'h6, 1'b0}},
        '{'{MODE_POLL,      8'h00, 16'hFFFF, 1'b0, 1'b0}, 1'b1, '{4'h0, 1'b0}},
        '{'{MODE_POLL,      8'h00, 16'hFFFF, 1'b0, 1'b1}, 1'b1, '{4'h0, 1'b0}},
        '{'{MODE_POLL,      8'h00, 16'hFFFF, 1'b1, 1'b1}, 1'b1, '{4'h0, 1'b0}},
        '{'{MODE_POLL,      8'h00, 16'hFFFF, 1'b1, 1'b0}, 1'b1, '{4'h1, 1'b0}},
        '{'{MODE_POLL,      8'h00, 16'h0000, 1'b1, 1'b0}, 1'b1, '{4'h1, 1'b0}},
        '{'{MODE_MAKE,      8'hFF, 16'h0000, 1'b0, 1'b0}, 1'b0, '{4'h0, 1'b0}},
        '{'{MODE_BREAK,     8'h00, 16'hFFFF, 1'b1, 1'b1}, 1'b0, '{4'h0, 1'b0}},
        '{'{MODE_RELEASE,   8'hFF, 16'h0000, 1'b0, 1'b0}, 1'b1, '{4'h0, 1'b0}},
        '{'{MODE_MAKE,      8'h80, 16'h0000, 1'b0, 1'b0}, 1'b0, '{4'h0, 1'b0}},
        '{'{MODE_RELEASE,   8'h00, 16'h0000, 1'b0, 1'b0}, 1'b1, '{4'h0, 1'b1}},
        '{'{MODE_SPARE_LO,  8'hFF, 16'hFFFF, 1'b1, 1'b1}, 1'b1, '{4'h0, 1'b0}},
        '{'{MODE_SPARE_MID, 8'hFF, 16'hFFFF, 1'b0, 1'b1}, 1'b1, '{4'h0, 1'b0}},
        '{'{MODE_SPARE_HI,  8'hFF, 16'hFFFF, 1'b1, 1'b0}, 1'b1, '{4'h0, 1'b0}},
        '{'{MODE_RESTART,   8'hFF, 16'hFFFF, 1'b1, 1'b1}, 1'b1, '{4'h0, 1'b0}},
        '{'{MODE_POLL,      8'h00, 16'h0000, 1'b1, 1'b0}, 1'b1, '{4'h3, 1'b0}},
        '{'{MODE_POLL,      8'h00, 16'h0000, 1'b1, 1'b0}, 1'b1, '{4'h3, 1'b0}},
        '{'{MODE_POLL,      8'h00, 16'h0000, 1'b0, 1'b0}, 1'b1, '{4'h4, 1'b0}}
    };

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    kens_in_if  in_ch ();
    kens_out_if out_ch ();

    keyboard_event_nibble_serializer DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // Predictor state: configuration copy and the event ring.
    logic [7:0]  id_byte   = DEVICE_ID_RESET;
    logic        caps_on   = 1'b0;
    logic        num_on    = 1'b0;
    logic        scroll_on = 1'b0;
    event_t      ring [QUEUE_DEPTH];
    int unsigned head_ptr  = 0;
    int unsigned tail_ptr  = 0;
    logic [7:0]  last_key  = '0;
    int unsigned nib_pos   = 0;
    logic        sent_any  = 1'b0;
    logic        sel_valid = 1'b0;
    logic [1:0]  last_sel  = '0;

    kens_result_t due_nibbles [$];
    logic [1:0]   host_sel       = '0;
    int unsigned  send_idle_pct  = 0;
    int unsigned  recv_stall_pct = 0;
    int unsigned  live_beats     = 0;
    int unsigned  mismatches     = 0;
    int unsigned  cycles         = 0;
    int unsigned  events_queued  = 0;
    int unsigned  full_drops     = 0;
    int unsigned  head_pops      = 0;
    int unsigned  repeats        = 0;

    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    function automatic logic ring_empty();
        return head_ptr == tail_ptr;
    endfunction

    function automatic logic enqueue_event(input logic [7:0] code, input logic brk);
        int unsigned nxt;
        nxt = (tail_ptr + 1) % QUEUE_DEPTH;
        if (nxt == head_ptr)
        begin
            full_drops++;
            return 1'b0;
        end
        ring[tail_ptr] = '{brk: brk, code: code};
        tail_ptr = nxt;
        events_queued++;
        return 1'b1;
    endfunction

    function automatic logic [NIBBLE_W-1:0] nibble_at(input int unsigned pos,
                                                      input logic [PAD_W-1:0] pad);
        event_t              head;
        logic [NIBBLE_W-1:0] status;
        logic [7:0]          lock_byte;
        logic [7:0]          low_keys;
        head      = ring_empty() ? '0 : ring[head_ptr];
        status    = ring_empty() ? STATUS_EMPTY : (head.brk ? STATUS_BREAK : STATUS_MAKE);
        lock_byte = {1'b0, caps_on, num_on, scroll_on, status};
        low_keys  = pad[7:0] & GAME_LOW_MASK;
        case (pos)
            0:       return id_byte[7:4];
            1:       return id_byte[3:0];
            2:       return pad[15:12];
            3:       return pad[11:8];
            4:       return low_keys[7:4];
            5:       return low_keys[3:0];
            6:       return lock_byte[7:4];
            7:       return lock_byte[3:0];
            8:       return head.code[7:4];
            9:       return head.code[3:0];
            10:      return 4'h0;
            default: return 4'h1;
        endcase
    endfunction

    // Works out the result of one accepted beat and advances the predictor state.
    function automatic kens_result_t serialize_beat(input kens_beat_t b);
        kens_result_t r;
        logic [1:0]   sel;
        int unsigned  pos;
        r   = '0;
        sel = {b.sel_hi, b.sel_lo};
        case (b.mode)
            MODE_POLL:
            begin
                if (!sel_valid || sel != last_sel)
                begin
                    pos = nib_pos;
                    r.nibble = nibble_at(pos, b.pad);
                    if (pos == LAST_NIBBLE && !ring_empty())
                    begin
                        head_ptr = (head_ptr + 1) % QUEUE_DEPTH;
                        head_pops++;
                    end
                    nib_pos   = (pos + 1) % PACKET_NIBBLES;
                    sent_any  = 1'b1;
                    last_sel  = sel;
                    sel_valid = 1'b1;
                end
                else
                begin
                    repeats++;
                    r.nibble = sent_any ? nibble_at((nib_pos + PACKET_NIBBLES - 1) %
                                                    PACKET_NIBBLES, b.pad)
                                        : nibble_at(0, b.pad);
                end
            end
            MODE_MAKE:
            begin
                last_key   = b.key;
                r.accepted = enqueue_event(b.key, 1'b0);
            end
            MODE_BREAK:
            begin
                last_key   = b.key;
                r.accepted = enqueue_event(b.key, 1'b1);
            end
            MODE_RELEASE:
            begin
                if (last_key != '0)
                    r.accepted = enqueue_event(last_key, 1'b1);
            end
            MODE_RESTART:
            begin
                nib_pos   = 0;
                sent_any  = 1'b0;
                sel_valid = 1'b0;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic send_beat(input kens_beat_t b, input logic typed, input kens_result_t want);
        kens_result_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.mode        = b.mode;
        in_ch.key_code    = b.key;
        in_ch.pad_buttons = b.pad;
        in_ch.select_low  = b.sel_lo;
        in_ch.select_high = b.sel_hi;
        in_ch.valid       = 1'b1;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predicted = serialize_beat(b);
        // Typed rows carry the value read off the packet layout directly.
        due_nibbles.push_back(typed ? want : predicted);
        if (b.mode == MODE_POLL)
            host_sel = {b.sel_hi, b.sel_lo};
        if (b.mode <= MODE_RESTART)
            live_beats++;
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (due_nibbles.size() != 0)
            @(negedge clk);
    endtask

    // Writes a register over APB, reads it back and updates the predictor copy.
    task automatic program_register(input reg_index_t idx, input logic [DATA_W-1:0] val);
        logic [DATA_W-1:0] readback;
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_DEVICE_ID:   id_byte   = val[7:0];
            REG_CAPS_LOCK:   caps_on   = val[0];
            REG_NUM_LOCK:    num_on    = val[0];
            REG_SCROLL_LOCK: scroll_on = val[0];
            default:
            begin
            end
        endcase
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        readback = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (readback !== val)
            report_mismatch($sformatf("register %s read back %h, wrote %h",
                                      idx.name(), readback, val));
    endtask

    task automatic push_burst();
        kens_beat_t  b;
        int unsigned pick;
        repeat ($urandom_range(1, 20))
        begin
            pick     = $urandom_range(99);
            b.mode   = (pick < 45) ? MODE_MAKE : ((pick < 85) ? MODE_BREAK : MODE_RELEASE);
            b.key    = ($urandom_range(15) == 0) ? 8'h00 : 8'($urandom);
            b.pad    = 16'($urandom);
            b.sel_hi = 1'($urandom);
            b.sel_lo = 1'($urandom);
            send_beat(b, 1'b0, '0);
        end
    endtask

    // Host reads nibbles by stepping the select lines, sometimes holding them still.
    task automatic read_packet(input logic restart_first);
        kens_beat_t       b;
        logic [PAD_W-1:0] pad;
        logic [1:0]       sel;
        int unsigned      len;
        if (restart_first)
        begin
            b.mode   = MODE_RESTART;
            b.key    = 8'($urandom);
            b.pad    = 16'($urandom);
            b.sel_hi = 1'($urandom);
            b.sel_lo = 1'($urandom);
            send_beat(b, 1'b0, '0);
        end
        len = ($urandom_range(3) == 0) ? $urandom_range(1, 2 * PACKET_NIBBLES) : PACKET_NIBBLES;
        pad = 16'($urandom);
        repeat (len)
        begin
            if ($urandom_range(7) == 0)
                pad = 16'($urandom);
            sel = ($urandom_range(99) < 15) ? host_sel : host_sel ^ 2'($urandom_range(1, 3));
            b.mode   = MODE_POLL;
            b.key    = 8'($urandom);
            b.pad    = pad;
            b.sel_hi = sel[1];
            b.sel_lo = sel[0];
            send_beat(b, 1'b0, '0);
        end
    endtask

    task automatic noise_beats();
        kens_beat_t b;
        repeat ($urandom_range(1, 3))
        begin
            b.mode   = MODE_W'($urandom_range(0, MODE_SPARE_HI));
            b.key    = 8'($urandom);
            b.pad    = 16'($urandom);
            b.sel_hi = 1'($urandom);
            b.sel_lo = 1'($urandom);
            send_beat(b, 1'b0, '0);
        end
    endtask

    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        kens_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (due_nibbles.size() == 0)
                report_mismatch("result beat arrived with nothing pending");
            else
            begin
                want = due_nibbles.pop_front();
                if (out_ch.data_nibble !== want.nibble)
                    report_mismatch($sformatf("data_nibble %h, expected %h",
                                              out_ch.data_nibble, want.nibble));
                if (out_ch.push_accepted !== want.accepted)
                    report_mismatch($sformatf("push_accepted %b, expected %b",
                                              out_ch.push_accepted, want.accepted));
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("Timed out after %0d cycles with %0d results pending.",
                         cycles, due_nibbles.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned      target;
        int unsigned      pick;
        logic [7:0]       id_val;
        logic [2:0]       lock_val;

        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_ch.valid       = 1'b0;
        in_ch.mode        = MODE_POLL;
        in_ch.key_code    = '0;
        in_ch.pad_buttons = '0;
        in_ch.select_low  = 1'b0;
        in_ch.select_high = 1'b0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < $size(DIRECTED_ROWS); i++)
            send_beat(DIRECTED_ROWS[i].beat, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            // Registers change only with the pipeline empty.
            hold_until_drained();
            repeat (4)
                @(negedge clk);
            case (phase)
                0:
                begin
                    id_val   = 8'h00;
                    lock_val = 3'b111;
                end
                1:
                begin
                    id_val   = 8'hFF;
                    lock_val = 3'b000;
                end
                default:
                begin
                    id_val   = 8'($urandom);
                    lock_val = 3'($urandom);
                end
            endcase
            program_register(REG_DEVICE_ID, {24'h0, id_val});
            program_register(REG_CAPS_LOCK, {31'h0, lock_val[2]});
            program_register(REG_NUM_LOCK, {31'h0, lock_val[1]});
            program_register(REG_SCROLL_LOCK, {31'h0, lock_val[0]});

            case (phase % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 76;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 76;
                end
                default:
                begin
                    send_idle_pct  = 13;
                    recv_stall_pct = 13;
                end
            endcase

            target = live_beats + PHASE_BEATS;
            while (live_beats < target)
            begin
                if ($urandom_range(63) == 0)
                    hold_until_drained();
                pick = $urandom_range(99);
                if (pick < 30)
                    push_burst();
                else if (pick < 80)
                    read_packet(1'b0);
                else if (pick < 90)
                    read_packet(1'b1);
                else
                    noise_beats();
            end
        end

        hold_until_drained();
        repeat (TAIL_CYCLES)
            @(posedge clk);

        $display("Ran %0d beats over %0d register settings: %0d events queued, %0d refused full.",
                 live_beats, PHASE_COUNT, events_queued, full_drops);
        $display("Host side saw %0d head pops and %0d held selects; %0d mismatches.",
                 head_pops, repeats, mismatches);
        if (mismatches == 0 && due_nibbles.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/kens_pkg.sv
src/kens_stream_if.sv
src/keyboard_event_nibble_serializer.sv
dv/keyboard_event_nibble_serializer_tb.sv
